### rtl/pls_pkg.sv
// types, constants and pattern tables of the led and buzzer pattern sequencer
`default_nettype none
package pls_pkg;

   // pattern classes, numerically equal to their priority
   typedef logic [1:0] class_type;
   localparam class_type CLASS_IDLE  = 2'd0;
   localparam class_type CLASS_PASS  = 2'd1;
   localparam class_type CLASS_START = 2'd2;
   localparam class_type CLASS_STOP  = 2'd3;

   // request kinds carried on tuser
   localparam logic FUNC_EVENT = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // event codes
   typedef logic [2:0] event_type;
   localparam event_type EV_NONE   = 3'd0;
   localparam event_type EV_START  = 3'd1;
   localparam event_type EV_PASS_A = 3'd2;
   localparam event_type EV_PASS_B = 3'd3;
   localparam event_type EV_PASS_C = 3'd4;
   localparam event_type EV_PASS_D = 3'd5;
   localparam event_type EV_STOP   = 3'd6;
   localparam event_type EV_SPARE  = 3'd7;   // unassigned, behaves like none

   localparam int unsigned TimeWidth = 16;
   localparam int unsigned StepWidth = 2;

   typedef logic [TimeWidth-1:0] time_type;
   typedef logic [StepWidth-1:0] step_type;

   // sequencer state
   typedef struct packed {
      class_type cls;
      step_type  step;
      time_type  time_left;
      logic      led;
      logic      buz;
   } seq_state_type;

   // one step of a pattern
   typedef struct packed {
      time_type dur;
      logic     led;
      logic     buz;
   } step_rom_type;

   // map an event code onto its pattern class
   function automatic class_type class_of_event(input event_type code);
      class_type cls;
      case (code) inside
         EV_START: cls = CLASS_START;
         EV_PASS_A, EV_PASS_B, EV_PASS_C, EV_PASS_D: cls = CLASS_PASS;
         EV_STOP: cls = CLASS_STOP;
         default: cls = CLASS_IDLE;
      endcase
      return cls;
   endfunction

   // number of steps in each pattern
   function automatic logic [StepWidth:0] steps_in_pattern(input class_type cls);
      logic [StepWidth:0] n;
      case (cls)
         CLASS_PASS:  n = 3'd2;
         CLASS_START: n = 3'd4;
         CLASS_STOP:  n = 3'd3;
         default:     n = 3'd0;
      endcase
      return n;
   endfunction

   // pattern rom: duration, led and buzzer level of each step
   function automatic step_rom_type step_rom(input class_type cls, input step_type step);
      step_rom_type s;
      case ({cls, step})
         {CLASS_START, 2'd0}: s = '{dur: 16'd80,  led: 1'b1, buz: 1'b1};
         {CLASS_START, 2'd1}: s = '{dur: 16'd80,  led: 1'b0, buz: 1'b0};
         {CLASS_START, 2'd2}: s = '{dur: 16'd80,  led: 1'b1, buz: 1'b1};
         {CLASS_START, 2'd3}: s = '{dur: 16'd80,  led: 1'b0, buz: 1'b0};
         {CLASS_PASS,  2'd0}: s = '{dur: 16'd80,  led: 1'b1, buz: 1'b1};
         {CLASS_PASS,  2'd1}: s = '{dur: 16'd40,  led: 1'b0, buz: 1'b0};
         {CLASS_STOP,  2'd0}: s = '{dur: 16'd350, led: 1'b1, buz: 1'b1};
         {CLASS_STOP,  2'd1}: s = '{dur: 16'd450, led: 1'b1, buz: 1'b0};
         {CLASS_STOP,  2'd2}: s = '{dur: 16'd120, led: 1'b0, buz: 1'b0};
         default:             s = '{dur: '0,      led: 1'b0, buz: 1'b0};
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

### rtl/priority_led_buzzer_pattern_sequencer.sv
// top level of the priority led and buzzer pattern sequencer
// Plays fixed led/buzzer patterns (start, pass, stop) driven by event and
// tick requests. Every request yields exactly one response carrying the led
// and buzzer levels and the running pattern class after that request. The
// block takes one request per clock cycle unless the response is stalled,
// and the response appears in the cycle after: the next state is worked out
// combinationally from the state registers and the incoming request, and is
// written together with the response register. A request is taken whenever
// the response register is empty or its content is being taken in the same cycle.
`default_nettype none
module priority_led_buzzer_pattern_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // event_code [2:0], elapsed [18:3], zero pad
   input  logic        req_tuser,  // func: 0 event, 1 tick
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // led_on [0], buzz_on [1], active_class [3:2], zero pad
);
   import pls_pkg::*;

   seq_state_type state_ff;
   seq_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [3:0]    rsp_data_ff;
   logic [3:0]    rsp_data_in;
   logic          take;

   // handshake
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   // per-request state update
   pls_next u_next (
      .state      (state_ff),
      .func       (req_tuser),
      .event_code (req_tdata[2:0]),
      .elapsed    (req_tdata[18:3]),
      .state_next (state_in)
   );

   // response register contents
   assign rsp_data_in  = {state_in.cls, state_in.buz, state_in.led};
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_tready);

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '{cls: CLASS_IDLE, step: '0, time_left: '0, led: 1'b0, buz: 1'b0};
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            state_ff <= state_in;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

endmodule
`default_nettype wire

### rtl/pls_next.sv
// next-state logic of the pattern sequencer for one request
`default_nettype none
module pls_next (
   input  pls_pkg::seq_state_type state,
   input  logic                   func,
   input  pls_pkg::event_type     event_code,
   input  pls_pkg::time_type      elapsed,
   output pls_pkg::seq_state_type state_next
);
   import pls_pkg::*;

   class_type          ev_class;
   logic               ev_takes;
   logic               run_out;
   logic [StepWidth:0] step_inc;
   logic               last_step;
   step_rom_type       start_entry;
   step_rom_type       adv_entry;

   // event decode and priority check
   assign ev_class = class_of_event(event_code);
   assign ev_takes = (ev_class != CLASS_IDLE)
                     && ((state.cls == CLASS_IDLE) || (ev_class >= state.cls));

   // tick timing
   assign run_out   = elapsed >= state.time_left;
   assign step_inc  = {1'b0, state.step} + 3'd1;
   assign last_step = step_inc >= steps_in_pattern(state.cls);

   // rom reads for a fresh pattern and for the following step
   assign start_entry = step_rom(ev_class, '0);
   assign adv_entry   = step_rom(state.cls, step_inc[StepWidth-1:0]);

   // choose the next state
   always_comb begin
      state_next = state;
      if (func == FUNC_EVENT) begin
         if (ev_takes) begin
            state_next.cls       = ev_class;
            state_next.step      = '0;
            state_next.time_left = start_entry.dur;
            state_next.led       = start_entry.led;
            state_next.buz       = start_entry.buz;
         end
      end else if (state.cls == CLASS_IDLE) begin
         state_next.led = 1'b0;
         state_next.buz = 1'b0;
      end else if (run_out) begin
         if (last_step) begin
            state_next = '{cls: CLASS_IDLE, step: '0, time_left: '0, led: 1'b0, buz: 1'b0};
         end else begin
            state_next.step      = step_inc[StepWidth-1:0];
            state_next.time_left = adv_entry.dur;
            state_next.led       = adv_entry.led;
            state_next.buz       = adv_entry.buz;
         end
      end else begin
         state_next.time_left = state.time_left - elapsed;
      end
   end

endmodule
`default_nettype wire

### tb/testbench.sv
// self-checking testbench for the priority led and buzzer pattern sequencer
module testbench;
   import pls_pkg::*;

   // one request as the sender sees it
   typedef struct packed {
      logic      func;
      event_type code;
      time_type  elapsed;
   } request_type;

   // levels and class reported in one response
   typedef struct packed {
      class_type cls;
      logic      buz;
      logic      led;
   } levels_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // event_code [2:0], elapsed [18:3], zero pad
   logic        req_tuser = 1'b0; // func: 0 event, 1 tick
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // led_on [0], buzz_on [1], active_class [3:2], zero pad

   // shadow copy of the sequencer state
   class_type  shadow_class = CLASS_IDLE;
   step_type   shadow_step = '0;
   time_type   shadow_time_left = '0;
   logic       shadow_led = 1'b0;
   logic       shadow_buz = 1'b0;

   levels_type expected_levels_q[$];
   int         failure_count = 0;
   int         sender_idle_pct = 0;
   int         receiver_idle_pct = 0;
   int         holdoff_cycles = 0;

   priority_led_buzzer_pattern_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #3000000;
      $display("Test completed with failures");
      $finish;
   end

   // pattern class that an event code asks for
   function automatic class_type pattern_of_event(input event_type code);
      case (code)
         EV_STOP:  return CLASS_STOP;
         EV_START: return CLASS_START;
         EV_PASS_A, EV_PASS_B, EV_PASS_C, EV_PASS_D: return CLASS_PASS;
         default:  return CLASS_IDLE;
      endcase
   endfunction

   // number of steps in a pattern
   function automatic int pattern_length(input class_type cls);
      case (cls)
         CLASS_START: return 4;
         CLASS_STOP:  return 3;
         CLASS_PASS:  return 2;
         default:     return 0;
      endcase
   endfunction

   // duration and levels of one step, from a flat table of all patterns
   function automatic step_rom_type pattern_step(input class_type cls, input step_type step);
      int index;
      step_rom_type s;
      case (cls)
         CLASS_START: index = int'(step);
         CLASS_PASS:  index = 4 + int'(step);
         CLASS_STOP:  index = 6 + int'(step);
         default:     index = -1;
      endcase
      case (index)
         0, 2, 4: s = '{dur: 16'd80,  led: 1'b1, buz: 1'b1};
         1, 3:    s = '{dur: 16'd80,  led: 1'b0, buz: 1'b0};
         5:       s = '{dur: 16'd40,  led: 1'b0, buz: 1'b0};
         6:       s = '{dur: 16'd350, led: 1'b1, buz: 1'b1};
         7:       s = '{dur: 16'd450, led: 1'b1, buz: 1'b0};
         8:       s = '{dur: 16'd120, led: 1'b0, buz: 1'b0};
         default: s = '{dur: 16'd0,   led: 1'b0, buz: 1'b0};
      endcase
      return s;
   endfunction

   // enter a step of the running pattern
   task automatic enter_step(input step_type step);
      step_rom_type s;
      s = pattern_step(shadow_class, step);
      shadow_step = step;
      shadow_time_left = s.dur;
      shadow_led = s.led;
      shadow_buz = s.buz;
   endtask

   // advance the shadow state by one accepted request and queue its levels
   task automatic predict_levels(input request_type r);
      class_type cls;
      levels_type want;
      if (r.func == FUNC_EVENT) begin
         cls = pattern_of_event(r.code);
         if (cls != CLASS_IDLE && (shadow_class == CLASS_IDLE || cls >= shadow_class)) begin
            shadow_class = cls;
            enter_step('0);
         end
      end else if (shadow_class == CLASS_IDLE) begin
         shadow_led = 1'b0;
         shadow_buz = 1'b0;
      end else if (r.elapsed >= shadow_time_left) begin
         if (int'(shadow_step) + 1 >= pattern_length(shadow_class)) begin
            shadow_class = CLASS_IDLE;
            shadow_step = '0;
            shadow_time_left = '0;
            shadow_led = 1'b0;
            shadow_buz = 1'b0;
         end else begin
            enter_step(shadow_step + 2'd1);
         end
      end else begin
         shadow_time_left = shadow_time_left - r.elapsed;
      end
      want.led = shadow_led;
      want.buz = shadow_buz;
      want.cls = shadow_class;
      expected_levels_q.push_back(want);
   endtask

   // event request, elapsed field carries noise
   function automatic request_type event_req(input event_type code);
      request_type r;
      r.func = FUNC_EVENT;
      r.code = code;
      r.elapsed = time_type'($urandom);
      return r;
   endfunction

   // tick request, event field carries noise
   function automatic request_type tick_req(input time_type ms);
      request_type r;
      r.func = FUNC_TICK;
      r.code = event_type'($urandom_range(0, 7));
      r.elapsed = ms;
      return r;
   endfunction

   // elapsed time aimed at the step boundaries of the running pattern
   function automatic time_type random_elapsed();
      case ($urandom_range(0, 9))
         0, 1:    return shadow_time_left;
         2:       return '0;
         3:       return shadow_time_left + time_type'($urandom_range(1, 40));
         4:       return time_type'($urandom);
         default: return time_type'($urandom_range(1, 60));
      endcase
   endfunction

   // drive one request and wait until it is accepted
   task automatic send_request(input request_type r);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.func;
      req_tdata <= {5'd0, r.elapsed, r.code};
      do @(posedge clock); while (!req_tready);
      predict_levels(r);
   endtask

   // stop offering requests until every response is back
   task automatic wait_for_responses();
      int guard = 0;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_levels_q.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // response side back-pressure, with an optional long hold-off
   always @(negedge clock) begin
      if (holdoff_cycles > 0) begin
         rsp_tready <= 1'b0;
         holdoff_cycles = holdoff_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // compare each response with the oldest expectation
   always @(posedge clock) begin : check_responses
      levels_type want;
      levels_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.led = rsp_tdata[0];
         got.buz = rsp_tdata[1];
         got.cls = class_type'(rsp_tdata[3:2]);
         if (expected_levels_q.size() == 0) begin
            failure_count++;
            if (failure_count <= 10)
               $display("unexpected response: led %0b buzzer %0b class %0d",
                        got.led, got.buz, got.cls);
         end else begin
            want = expected_levels_q.pop_front();
            if (got.led !== want.led || got.buz !== want.buz || got.cls !== want.cls) begin
               failure_count++;
               if (failure_count <= 10)
                  $display({"mismatch: expected led %0b buzzer %0b class %0d,",
                            " got led %0b buzzer %0b class %0d"},
                           want.led, want.buz, want.cls, got.led, got.buz, got.cls);
            end
         end
      end
   end

   // ticks while idle and events that carry no pattern
   task automatic test_idle_and_ignored_events();
      send_request(tick_req(16'd0));
      send_request(tick_req(16'hFFFF));
      send_request(event_req(EV_NONE));
      send_request(event_req(EV_SPARE));
   endtask

   // priority rules, restarts and step boundaries of every pattern
   task automatic test_priority_and_step_timing();
      send_request(event_req(EV_START));
      send_request(event_req(EV_PASS_A));
      send_request(event_req(EV_STOP));
      send_request(event_req(EV_START));
      send_request(event_req(EV_PASS_D));
      send_request(event_req(EV_STOP));
      send_request(tick_req(16'd350));
      send_request(tick_req(16'd0));
      send_request(tick_req(16'd449));
      send_request(tick_req(16'd1));
      send_request(tick_req(16'hFFFF));
      send_request(event_req(EV_PASS_B));
      send_request(event_req(EV_PASS_C));
      send_request(event_req(EV_START));
      send_request(tick_req(16'd80));
      send_request(tick_req(16'd100));
      send_request(tick_req(16'd200));
      send_request(tick_req(16'd80));
      send_request(event_req(EV_PASS_D));
      send_request(tick_req(16'd79));
      send_request(tick_req(16'd1));
      send_request(tick_req(16'hFFFF));
   endtask

   // mostly whole patterns with random timing, some interruptions and noise
   task automatic test_random_patterns(input int count);
      request_type r;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (shadow_class == CLASS_IDLE && pick < 60)
            r = event_req(event_type'($urandom_range(1, 6)));
         else if (pick < 88)
            r = tick_req(random_elapsed());
         else if (pick < 95)
            r = event_req(event_type'($urandom_range(1, 6)));
         else
            r = event_req($urandom_range(0, 1) ? EV_NONE : EV_SPARE);
         send_request(r);
         if ($urandom_range(0, 99) < 2)
            wait_for_responses();
      end
   endtask

   // long response stall so the input stalls, then a full pause
   task automatic test_response_holdoff();
      holdoff_cycles = 300;
      test_random_patterns(40);
      wait_for_responses();
      test_random_patterns(20);
   endtask

   // main sequence
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct = 13;
      receiver_idle_pct = 77;
      test_idle_and_ignored_events();
      test_priority_and_step_timing();
      test_random_patterns(170);

      sender_idle_pct = 77;
      receiver_idle_pct = 13;
      test_random_patterns(170);

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_random_patterns(150);
      test_response_holdoff();

      wait_for_responses();
      repeat (5) @(posedge clock);
      if (expected_levels_q.size() != 0) begin
         failure_count++;
         $display("%0d expected responses never arrived", expected_levels_q.size());
      end
      if (failure_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### filelist.f
rtl/pls_pkg.sv
rtl/pls_next.sv
rtl/priority_led_buzzer_pattern_sequencer.sv
tb/testbench.sv
